### rtl/assert_macros.svh
// Assertion macros shared by the spline evaluator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define ASSERT_CHK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Antecedent implies consequent in the following cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/bcz_pkg.sv
// Shared types and constants of the cubic Bezier spline evaluator.
package bcz_pkg;

	// default sizing
	localparam int DEF_MAX_SEGMENTS = 64;
	localparam int DEF_COORD_BITS   = 16;

	// port field widths
	localparam int IN_BITS        = 16;
	localparam int OUT_BITS       = 16;
	localparam int T_BITS         = 16;
	localparam int T_FRAC_BITS    = 15;
	localparam int SEG_COUNT_BITS = 7;

	localparam logic [T_BITS-1:0]         T_ONE           = 16'h8000;
	localparam int                        ROUND_HALF      = 16384;
	localparam logic [SEG_COUNT_BITS-1:0] SEG_COUNT_RESET = 7'd1;

	// operation codes
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_MOVE  = 2'd1;
	localparam logic [1:0] OP_EVAL  = 2'd2;

	// de Casteljau schedule over a four-entry shift line: set bit = interpolate
	// the two head entries, clear bit = drop the head entry only
	localparam int            STEP_COUNT   = 9;
	localparam logic [3:0]    LAST_STEP    = 4'd8;
	localparam logic [STEP_COUNT-1:0] STEP_IS_LERP = 9'b1_0011_0111;

	// store port controls
	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} mem_ctl_t;

	// sequencer states
	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_MADD  = 6'b000010,
		ST_ERD   = 6'b000100,
		ST_EWAIT = 6'b001000,
		ST_ELERP = 6'b010000,
		ST_EDONE = 6'b100000
	} state_t;

endpackage

### rtl/bcz_store.sv
// Control point store: one write port, one read port with registered data.
module bcz_store import bcz_pkg::*; #(
	parameter int DEPTH = 3 * DEF_MAX_SEGMENTS + 1,
	parameter int AW    = $clog2(3 * DEF_MAX_SEGMENTS + 1),
	parameter int DW    = 2 * DEF_COORD_BITS
) (
	input  logic          clk,
	input  mem_ctl_t      ctl,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered data
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/bcz_lerp.sv
// Two-stage linear interpolation a + round((b - a) * t) in Q1.15 t.
module bcz_lerp import bcz_pkg::*; #(
	parameter int COORD_BITS = DEF_COORD_BITS
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [COORD_BITS-1:0] a,
	input  logic signed [COORD_BITS-1:0] b,
	input  logic        [T_BITS-1:0]     t,
	output logic signed [COORD_BITS-1:0] r
);

	localparam int DFW = COORD_BITS + 1;
	localparam int PW  = COORD_BITS + T_BITS + 2;

	logic signed [DFW-1:0]        diff;
	logic signed [T_BITS:0]       tf;
	logic signed [PW-1:0]         prod_s1;
	logic signed [COORD_BITS-1:0] a_s1;
	logic signed [PW-1:0]         rnd;
	logic signed [PW-1:0]         shq;

	assign diff = DFW'(b) - DFW'(a);
	assign tf   = $signed({1'b0, t});

	// stage 1: product
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= diff * tf;
			a_s1    <= a;
		end
	end

	// stage 2: round half up, floor shift, add base; result stays between a and b for t up to 1.0
	assign rnd = prod_s1 + PW'(ROUND_HALF);
	assign shq = rnd >>> T_FRAC_BITS;
	assign r   = a_s1 + $signed(shq[COORD_BITS-1:0]);

endmodule

### rtl/cubic_bezier_spline_evaluator.sv
// Top level of the cubic Bezier spline evaluator.
// The spline lives in a store of 3*MAX_SEGMENTS+1 (x, y) control points; segment s
// blends points 3s..3s+3. One transaction is handled at a time. A write stores the
// point directly; a move reads it, then saturating adds and writes back on the store's
// single port pair. An evaluate registers the request, makes four reads through the
// store's one read port and lets the last read land, then runs a de Casteljau pass of
// six interpolations, each a product step and a shift step, on one shared multiply unit per
// coordinate, plus three shift-only steps and a result state; a result waiting in the
// output register holds the next one back only in that result state. An evaluate of a
// segment at or beyond segment_count or MAX_SEGMENTS answers with zero coordinates
// and segment_error set, without reading the store. The store has no reset; points
// must be written before they are evaluated or moved.
`include "assert_macros.svh"

module cubic_bezier_spline_evaluator import bcz_pkg::*; #(
	parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
	parameter int COORD_BITS   = DEF_COORD_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [SEG_COUNT_BITS-1:0] cfg_data,
	// input channel
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                operation,
	input  logic [7:0]                point_index,
	input  logic [5:0]                segment_index,
	input  logic signed [IN_BITS-1:0] x_value,
	input  logic signed [IN_BITS-1:0] y_value,
	input  logic [T_BITS-1:0]         t_param,
	// output channel
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [OUT_BITS-1:0] curve_x,
	output logic signed [OUT_BITS-1:0] curve_y,
	output logic                      segment_error
);

	localparam int POINT_COUNT = 3 * MAX_SEGMENTS + 1;
	localparam int AW = $clog2(POINT_COUNT);
	localparam int DW = 2 * COORD_BITS;
	localparam int SW = ((COORD_BITS > IN_BITS) ? COORD_BITS : IN_BITS) + 1;
	localparam int EW = (COORD_BITS > OUT_BITS) ? COORD_BITS : OUT_BITS;

	localparam logic signed [SW-1:0] CHI =
		{{(SW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
	localparam logic signed [SW-1:0] CLO = ~CHI;
	localparam logic signed [EW-1:0] OHI =
		{{(EW-OUT_BITS+1){1'b0}}, {(OUT_BITS-1){1'b1}}};
	localparam logic signed [EW-1:0] OLO = ~OHI;

	// saturate to the store's coordinate range
	function automatic logic signed [COORD_BITS-1:0] sat_coord(input logic signed [SW-1:0] v);
		logic signed [SW-1:0] c;
		if (v > CHI) c = CHI;
		else if (v < CLO) c = CLO;
		else c = v;
		return c[COORD_BITS-1:0];
	endfunction

	// saturate to the output field range
	function automatic logic [OUT_BITS-1:0] sat_out(input logic signed [COORD_BITS-1:0] v);
		logic signed [EW-1:0] e;
		logic signed [EW-1:0] c;
		e = EW'(v);
		if (e > OHI) c = OHI;
		else if (e < OLO) c = OLO;
		else c = e;
		return c[OUT_BITS-1:0];
	endfunction

	state_t                      state_q;
	logic [SEG_COUNT_BITS-1:0]   segment_count_q;
	logic [1:0]                  cnt_q;
	logic [3:0]                  step_q;
	logic                        phase_q;
	logic                        rd_pend_q;
	logic                        out_valid_q;

	logic [AW-1:0]               addr_q;
	logic [AW-1:0]               base_q;
	logic signed [IN_BITS-1:0]   dx_q;
	logic signed [IN_BITS-1:0]   dy_q;
	logic [T_BITS-1:0]           t_q;
	logic                        err_q;
	logic signed [COORD_BITS-1:0] qx_q [4];
	logic signed [COORD_BITS-1:0] qy_q [4];
	logic [OUT_BITS-1:0]         curve_x_q;
	logic [OUT_BITS-1:0]         curve_y_q;
	logic                        seg_err_q;

	logic                        in_acc;
	logic                        pidx_ok;
	logic                        seg_err;
	logic [T_BITS-1:0]           t_sat;
	logic [7:0]                  seg3;
	logic                        step_lerp;
	logic                        lerp_en;
	logic                        shift_en;
	logic                        out_load;

	mem_ctl_t                    mem_ctl;
	logic [AW-1:0]               waddr;
	logic [DW-1:0]               wdata;
	logic [AW-1:0]               raddr;
	logic [DW-1:0]               rdata;
	logic signed [COORD_BITS-1:0] rd_x;
	logic signed [COORD_BITS-1:0] rd_y;
	logic signed [COORD_BITS-1:0] lerp_rx;
	logic signed [COORD_BITS-1:0] lerp_ry;
	logic signed [COORD_BITS-1:0] new_x;
	logic signed [COORD_BITS-1:0] new_y;

	// input decode
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign pidx_ok   = int'(point_index) < POINT_COUNT;
	assign seg_err   = (SEG_COUNT_BITS'(segment_index) >= segment_count_q) ||
	                   (int'(segment_index) >= MAX_SEGMENTS);
	assign t_sat     = (t_param > T_ONE) ? T_ONE : t_param;
	assign seg3      = {2'b00, segment_index} + {1'b0, segment_index, 1'b0};
	assign cfg_ready = 1'b1;

	assign rd_x = $signed(rdata[COORD_BITS-1:0]);
	assign rd_y = $signed(rdata[DW-1:COORD_BITS]);

	// store access per state
	always_comb begin
		mem_ctl = '0;
		waddr   = addr_q;
		wdata   = {sat_coord(SW'(rd_y) + SW'(dy_q)), sat_coord(SW'(rd_x) + SW'(dx_q))};
		raddr   = base_q + AW'(cnt_q);
		case (state_q)
			ST_IDLE: begin
				if (in_acc && pidx_ok) begin
					case (operation)
						OP_WRITE: begin
							mem_ctl.wr_en = 1'b1;
							waddr = AW'(point_index);
							wdata = {sat_coord(SW'(y_value)), sat_coord(SW'(x_value))};
						end
						OP_MOVE: begin
							mem_ctl.rd_en = 1'b1;
							raddr = AW'(point_index);
						end
						default: ;
					endcase
				end
			end
			ST_MADD: mem_ctl.wr_en = 1'b1;
			ST_ERD:  mem_ctl.rd_en = 1'b1;
			default: ;
		endcase
	end

	bcz_store #(
		.DEPTH (POINT_COUNT),
		.AW    (AW),
		.DW    (DW)
	) u_store (
		.clk   (clk),
		.ctl   (mem_ctl),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// interpolation units on the two head taps of the shift line
	assign step_lerp = STEP_IS_LERP[step_q];
	assign lerp_en   = (state_q == ST_ELERP) && !phase_q && step_lerp;
	assign shift_en  = (state_q == ST_ELERP) && (phase_q || !step_lerp);

	bcz_lerp #(.COORD_BITS(COORD_BITS)) u_lerp_x (
		.clk (clk), .en (lerp_en), .a (qx_q[0]), .b (qx_q[1]), .t (t_q), .r (lerp_rx)
	);

	bcz_lerp #(.COORD_BITS(COORD_BITS)) u_lerp_y (
		.clk (clk), .en (lerp_en), .a (qy_q[0]), .b (qy_q[1]), .t (t_q), .r (lerp_ry)
	);

	assign new_x    = rd_pend_q ? rd_x : lerp_rx;
	assign new_y    = rd_pend_q ? rd_y : lerp_ry;
	assign out_load = (state_q == ST_EDONE) && (!out_valid_q || !out_stall);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			step_q    <= '0;
			phase_q   <= 1'b0;
			rd_pend_q <= 1'b0;
		end else begin
			rd_pend_q <= (state_q == ST_ERD);
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (operation)
							OP_MOVE: if (pidx_ok) state_q <= ST_MADD;
							OP_EVAL: begin
								cnt_q   <= '0;
								state_q <= seg_err ? ST_EDONE : ST_ERD;
							end
							default: ;
						endcase
					end
				end
				ST_MADD: state_q <= ST_IDLE;
				ST_ERD: begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd3) state_q <= ST_EWAIT;
				end
				ST_EWAIT: begin
					step_q  <= '0;
					phase_q <= 1'b0;
					state_q <= ST_ELERP;
				end
				ST_ELERP: begin
					if (step_lerp && !phase_q) begin
						phase_q <= 1'b1;
					end else begin
						phase_q <= 1'b0;
						step_q  <= step_q + 4'd1;
						if (step_q == LAST_STEP) state_q <= ST_EDONE;
					end
				end
				ST_EDONE: if (out_load) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// transaction payload capture
	always_ff @(posedge clk) begin
		if (in_acc) begin
			addr_q <= AW'(point_index);
			base_q <= AW'(seg3);
			dx_q   <= x_value;
			dy_q   <= y_value;
			t_q    <= t_sat;
			err_q  <= seg_err;
		end
	end

	// shift line: filled by store reads, then fed by interpolation results
	always_ff @(posedge clk) begin
		if (rd_pend_q || shift_en) begin
			qx_q[0] <= qx_q[1];
			qx_q[1] <= qx_q[2];
			qx_q[2] <= qx_q[3];
			qx_q[3] <= new_x;
			qy_q[0] <= qy_q[1];
			qy_q[1] <= qy_q[2];
			qy_q[2] <= qy_q[3];
			qy_q[3] <= new_y;
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			segment_count_q <= SEG_COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			segment_count_q <= cfg_data;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			curve_x_q <= err_q ? '0 : sat_out(qx_q[3]);
			curve_y_q <= err_q ? '0 : sat_out(qy_q[3]);
			seg_err_q <= err_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign curve_x       = $signed(curve_x_q);
	assign curve_y       = $signed(curve_y_q);
	assign segment_error = seg_err_q;

	// checks
	`ASSERT_CHK(a_wr_state, clk, arst_n, mem_ctl.wr_en |-> (state_q == ST_IDLE || state_q == ST_MADD), "store written outside write or move")
	`ASSERT_CHK(a_rd_pend, clk, arst_n, rd_pend_q |-> $past(mem_ctl.rd_en && state_q == ST_ERD), "shift line fill without a point read")
	`ASSERT_CHK(a_out_src, clk, arst_n, $rose(out_valid) |-> $past(state_q == ST_EDONE), "result appeared outside result state")
	`ASSERT_CHK(a_err_zero, clk, arst_n, (out_valid && segment_error) |-> (curve_x == '0 && curve_y == '0), "segment error result with nonzero point")

endmodule
